// File: src/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Shared constants and codes for the clipped line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package clr_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int COLOR_WIDTH_DEF = 16;

  // Reset value of the right and bottom clip bounds.
  localparam int CLIP_MAX_RESET = 4095;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_TOP    = 2'd1,
    CFG_CLIP_RIGHT  = 2'd2,
    CFG_CLIP_BOTTOM = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_e;

endpackage

`default_nettype wire

// File: src/clipped_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_core
// Bresenham line stepper that marks each pixel visible against the
// intersection of the line's bounding box and a clip rectangle.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  -------  ---------  ----------------------  ------------------------------
//  in       input      in_valid_i/in_ready_o   func, start/end x y, line_color
//  out      output     out_valid_o/out_ready_i pixel x y, color, flags
//  cfg      input      cfg_we_i                cfg_index_i, cfg_wdata_i
//
// Every item gives one registered result item; the block sustains one
// item per clock while results are taken. The work for an item is one add,
// compare and subtract on the error term between the state registers and
// the result register. A skid register behind the result register lets one
// more item in while a result is stalled; ready falls only when both hold.
// Reset clears the line state and sets the clip rectangle to its defaults.
`default_nettype none

module clipped_line_rasterizer_core #(
  parameter int COORD_WIDTH = clr_pkg::COORD_WIDTH_DEF,
  parameter int COLOR_WIDTH = clr_pkg::COLOR_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [clr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [COORD_WIDTH-1:0]        start_x_i,
  input  logic [COORD_WIDTH-1:0]        start_y_i,
  input  logic [COORD_WIDTH-1:0]        end_x_i,
  input  logic [COORD_WIDTH-1:0]        end_y_i,
  input  logic [COLOR_WIDTH-1:0]        line_color_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COORD_WIDTH-1:0]        pixel_x_o,
  output logic [COORD_WIDTH-1:0]        pixel_y_o,
  output logic [COLOR_WIDTH-1:0]        pixel_color_o,
  output logic                          visible_o,
  output logic                          last_pixel_o,
  output logic                          idle_step_o
);

  import clr_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int EW    = COORD_WIDTH + 1;
  localparam int RES_W = 2 * COORD_WIDTH + COLOR_WIDTH + 3;
  localparam logic [CW-1:0] ClipMax = CW'(CLIP_MAX_RESET);

  // Clip rectangle.
  logic [CW-1:0] clip_l_q, clip_t_q, clip_r_q, clip_b_q;

  // Line state.
  logic             active_q, active_d;
  logic [CW-1:0]    cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [EW-1:0]    err_q, err_d;
  logic [CW-1:0]    steps_q, steps_d;
  logic [CW-1:0]    dx_q, dx_d, dy_q, dy_d;
  logic             neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic             x_major_q, x_major_d;
  logic [COLOR_WIDTH-1:0] color_q, color_d;
  logic [CW-1:0]    box_l_q, box_l_d, box_t_q, box_t_d;
  logic [CW-1:0]    box_r_q, box_r_d, box_b_q, box_b_d;

  // Result and skid registers.
  logic             out_valid_q, skid_valid_q;
  logic [RES_W-1:0] out_q, skid_q;

  logic             in_accept;
  logic [RES_W-1:0] res;

  assign in_ready_o = !skid_valid_q;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_l_q <= '0;
      clip_t_q <= '0;
      clip_r_q <= ClipMax;
      clip_b_q <= ClipMax;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CLIP_LEFT:   clip_l_q <= cfg_wdata_i;
        CFG_CLIP_TOP:    clip_t_q <= cfg_wdata_i;
        CFG_CLIP_RIGHT:  clip_r_q <= cfg_wdata_i;
        CFG_CLIP_BOTTOM: clip_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [CW-1:0] nl, nt, nr, nb;
  logic [CW-1:0] sdx, sdy;
  logic          snx, sny, sxm;
  logic [CW-1:0] major, minor;
  logic [EW-1:0] err_sum;
  logic          minor_moves;
  logic [CW-1:0] nx, ny;
  logic [CW-1:0] px, py;
  logic [COLOR_WIDTH-1:0] pc;
  logic          vis, last, idle;

  always_comb begin
    active_d  = active_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    err_d     = err_q;
    steps_d   = steps_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    neg_x_d   = neg_x_q;
    neg_y_d   = neg_y_q;
    x_major_d = x_major_q;
    color_d   = color_q;
    box_l_d   = box_l_q;
    box_t_d   = box_t_q;
    box_r_d   = box_r_q;
    box_b_d   = box_b_q;
    px   = '0;
    py   = '0;
    pc   = '0;
    vis  = 1'b0;
    last = 1'b0;
    idle = 1'b0;

    // Start path: bounding box clipped against the window.
    lo_x = (start_x_i < end_x_i) ? start_x_i : end_x_i;
    hi_x = (start_x_i < end_x_i) ? end_x_i : start_x_i;
    lo_y = (start_y_i < end_y_i) ? start_y_i : end_y_i;
    hi_y = (start_y_i < end_y_i) ? end_y_i : start_y_i;
    nl   = (lo_x > clip_l_q) ? lo_x : clip_l_q;
    nt   = (lo_y > clip_t_q) ? lo_y : clip_t_q;
    nr   = (hi_x < clip_r_q) ? hi_x : clip_r_q;
    nb   = (hi_y < clip_b_q) ? hi_y : clip_b_q;
    snx  = end_x_i < start_x_i;
    sny  = end_y_i < start_y_i;
    sdx  = hi_x - lo_x;
    sdy  = hi_y - lo_y;
    sxm  = sdx >= sdy;

    // Step path: one error update along the major axis.
    major       = x_major_q ? dx_q : dy_q;
    minor       = x_major_q ? dy_q : dx_q;
    err_sum     = err_q + {1'b0, minor};
    minor_moves = err_sum >= {1'b0, major};
    nx = cur_x_q;
    ny = cur_y_q;
    if (x_major_q || minor_moves) begin
      nx = neg_x_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
    end
    if (!x_major_q || minor_moves) begin
      ny = neg_y_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
    end

    case (func_e'(func_i))
      FUNC_START: begin
        px      = start_x_i;
        py      = start_y_i;
        pc      = line_color_i;
        color_d = line_color_i;
        box_l_d = nl;
        box_t_d = nt;
        box_r_d = nr;
        box_b_d = nb;
        if (nl > nr || nt > nb) begin
          active_d = 1'b0;
          last     = 1'b1;
        end else begin
          cur_x_d   = start_x_i;
          cur_y_d   = start_y_i;
          neg_x_d   = snx;
          neg_y_d   = sny;
          dx_d      = sdx;
          dy_d      = sdy;
          x_major_d = sxm;
          steps_d   = sxm ? sdx : sdy;
          err_d     = {1'b0, steps_d} >> 1;
          vis       = start_x_i >= nl && start_x_i <= nr &&
                      start_y_i >= nt && start_y_i <= nb;
          active_d  = steps_d != '0;
          last      = !active_d;
        end
      end
      FUNC_STEP: begin
        if (!active_q) begin
          idle = 1'b1;
        end else begin
          err_d   = minor_moves ? err_sum - {1'b0, major} : err_sum;
          cur_x_d = nx;
          cur_y_d = ny;
          steps_d = steps_q - CW'(1);
          px      = nx;
          py      = ny;
          pc      = color_q;
          vis     = nx >= box_l_q && nx <= box_r_q &&
                    ny >= box_t_q && ny <= box_b_q;
          if (steps_d == '0) begin
            active_d = 1'b0;
            last     = 1'b1;
          end
        end
      end
      default: ;
    endcase

    res = {px, py, pc, vis, last, idle};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      err_q     <= '0;
      steps_q   <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      neg_x_q   <= 1'b0;
      neg_y_q   <= 1'b0;
      x_major_q <= 1'b0;
      color_q   <= '0;
      box_l_q   <= '0;
      box_t_q   <= '0;
      box_r_q   <= '0;
      box_b_q   <= '0;
    end else if (in_accept) begin
      active_q  <= active_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      err_q     <= err_d;
      steps_q   <= steps_d;
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      neg_x_q   <= neg_x_d;
      neg_y_q   <= neg_y_d;
      x_major_q <= x_major_d;
      color_q   <= color_d;
      box_l_q   <= box_l_d;
      box_t_q   <= box_t_d;
      box_r_q   <= box_r_d;
      box_b_q   <= box_b_d;
    end
  end

  // Result register with a skid stage behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_ready_i) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_accept;
        end
      end else if (in_accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign {pixel_x_o, pixel_y_o, pixel_color_o, visible_o, last_pixel_o, idle_step_o} = out_q;

endmodule

`default_nettype wire
